[hdl/matrix_vector_multiply_assert.svh]
// Assertion macros shared by the matrix-vector multiply RTL.
`ifndef MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`ifndef SYNTH
`define MVM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("matrix_vector_multiply: assertion failed");
`define MVM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("matrix_vector_multiply: assertion failed");
`else
`define MVM_ASSERT(lbl, clk, rst, prop)
`define MVM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/mvm_pkg.sv]
// Types and constants shared by the matrix-vector multiply modules.
package mvm_pkg;

  localparam int MAX_COLS_DEF = 1024;

  localparam int COL_W       = 10;
  localparam int VALUE_W     = 64;
  localparam int ROW_IDX_W   = 16;
  localparam int COLS_W      = 11;
  localparam int ROWS_W      = 17;
  localparam int CNT_W       = 17;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int COLS_RESET  = 1024;
  localparam int ROWS_RESET  = 65536;

  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int PEND_W      = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLS_IN_USE = 2'd0,
    REG_ROWS_IN_USE = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_MATRIX = 1'b1
  } op_t;

  typedef struct packed {
    logic               op;
    logic [COL_W-1:0]   col;
    logic [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   row_sum;
    logic [ROW_IDX_W-1:0] row_index;
  } out_t;

  typedef struct packed {
    logic valid;
    logic last;
  } mac_ctl_t;

endpackage

[hdl/mvm_vec_store.sv]
// Vector element store: one-port synchronous RAM with registered read data.
module mvm_vec_store #(
  parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEF,
  parameter int ADDR_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic                       re,
  input  logic [ADDR_W-1:0]          addr,
  input  logic [mvm_pkg::VALUE_W-1:0] wdata,
  output logic [mvm_pkg::VALUE_W-1:0] rdata
);
  import mvm_pkg::*;

  logic [VALUE_W-1:0] mem [MAX_COLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[hdl/mvm_mac.sv]
// Split 64-bit multiply pipeline and row accumulator with row counter.
`include "matrix_vector_multiply_assert.svh"
module mvm_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  mvm_pkg::mac_ctl_t            s1_ctl,
  input  logic [mvm_pkg::VALUE_W-1:0]  a,
  input  logic [mvm_pkg::VALUE_W-1:0]  b,
  input  logic [mvm_pkg::ROWS_W-1:0]   rows_in_use,
  output logic                         res_valid,
  output mvm_pkg::out_t                res,
  output logic [mvm_pkg::PEND_W-1:0]   pending
);
  import mvm_pkg::*;

  mac_ctl_t           s2_ctl;
  mac_ctl_t           s3_ctl;
  logic [63:0]        p_ll;
  logic [31:0]        p_lh;
  logic [31:0]        p_hl;
  logic [63:0]        ll;
  logic [31:0]        lh;
  logic [31:0]        hl;
  logic [63:0]        prod;
  logic [63:0]        running_sum;
  logic [63:0]        acc;
  logic [ROW_IDX_W-1:0] row_counter;
  logic [ROW_IDX_W-1:0] row_counter_next;
  logic [ROWS_W-1:0]  eff_rows;
  logic [ROWS_W-1:0]  row_inc;

  // Low 64 bits of the product need only three 32x32 partial products.
  assign ll = a[31:0] * b[31:0];
  assign lh = a[31:0] * b[63:32];
  assign hl = a[63:32] * b[31:0];

  always_ff @(posedge clk) begin
    p_ll <= ll;
    p_lh <= lh;
    p_hl <= hl;
    prod <= p_ll + {p_lh + p_hl, 32'd0};
  end

  always_comb begin
    eff_rows = rows_in_use;
    if (rows_in_use == '0 || rows_in_use > ROWS_W'(ROWS_RESET)) begin
      eff_rows = ROWS_W'(ROWS_RESET);
    end
    row_inc = ROWS_W'(row_counter) + ROWS_W'(1);
    row_counter_next = row_inc[ROW_IDX_W-1:0];
    if (row_inc >= eff_rows) begin
      row_counter_next = '0;
    end
  end

  assign acc           = running_sum + prod;
  assign res_valid     = s3_ctl.valid && s3_ctl.last;
  assign res.row_sum   = acc;
  assign res.row_index = row_counter;
  assign pending       = PEND_W'(s2_ctl.valid && s2_ctl.last)
                       + PEND_W'(s3_ctl.valid && s3_ctl.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl      <= '0;
      s3_ctl      <= '0;
      running_sum <= '0;
      row_counter <= '0;
    end else begin
      s2_ctl <= s1_ctl;
      s3_ctl <= s2_ctl;
      if (s3_ctl.valid) begin
        if (s3_ctl.last) begin
          running_sum <= '0;
          row_counter <= row_counter_next;
        end else begin
          running_sum <= acc;
        end
      end
    end
  end

  `MVM_ASSERT_NEXT(a_sum_clears, clk, rst, res_valid, running_sum == '0)
  `MVM_ASSERT(a_index_in_range, clk, rst, !res_valid || ROWS_W'(row_counter) < eff_rows || ROWS_W'(row_counter) >= ROWS_W'(rows_in_use))

endmodule

[hdl/mvm_out_fifo.sv]
// Result queue between the accumulator and the output channel.
`include "matrix_vector_multiply_assert.svh"
module mvm_out_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  mvm_pkg::out_t                   push_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mvm_pkg::out_t                   out_data,
  output logic [mvm_pkg::FIFO_CNT_W-1:0]  count
);
  import mvm_pkg::*;

  out_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign out_valid = count != '0;
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  `MVM_ASSERT(a_no_overflow, clk, rst, !(push && !pop && count == FIFO_CNT_W'(FIFO_DEPTH)))

endmodule

[hdl/matrix_vector_multiply.sv]
// Top level of the dense matrix-vector multiply over 64-bit integers mod 2^64.
//
//   channel  direction  handshake         payload
//   in       input      in_valid/in_stall in_data  (op, col, value)
//   out      output     out_valid/out_stall out_data (row_sum, row_index)
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One request enters per cycle while in_stall is low. A row result from the
// request at the last column passes vector store read, partial products,
// product sum, then the accumulator writes the eight-entry result queue.
// Input stall rises only when results in flight would overfill that queue.
// Reset is synchronous; the vector store is not cleared and needs no sweep.
`include "matrix_vector_multiply_assert.svh"
module matrix_vector_multiply #(
  parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mvm_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mvm_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mvm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mvm_pkg::*;

  localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int TOT_W  = FIFO_CNT_W + 1;

  logic [COLS_W-1:0]  cols_in_use;
  logic [ROWS_W-1:0]  rows_in_use;
  logic [CNT_W-1:0]   eff_cols;
  logic [CNT_W-1:0]   col_ext;
  logic               accept;
  logic               is_matrix;
  logic               we;
  logic               re;
  mac_ctl_t           s1_ctl;
  mac_ctl_t           s1_ctl_next;
  logic [VALUE_W-1:0] s1_value;
  logic [VALUE_W-1:0] vec_rdata;
  logic               res_valid;
  out_t               res;
  logic [PEND_W-1:0]  pending;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [TOT_W-1:0]   in_flight;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= COLS_W'(COLS_RESET);
      rows_in_use <= ROWS_W'(ROWS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLS_IN_USE: cols_in_use <= cfg_data[COLS_W-1:0];
        REG_ROWS_IN_USE: rows_in_use <= cfg_data[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_cols = (cols_in_use == '0) ? CNT_W'(1) : CNT_W'(cols_in_use);
    if (eff_cols > CNT_W'(MAX_COLS)) begin
      eff_cols = CNT_W'(MAX_COLS);
    end
  end

  assign col_ext   = CNT_W'(in_data.col);
  assign accept    = in_valid && !in_stall;
  assign is_matrix = in_data.op == OP_MATRIX;
  assign we        = accept && !is_matrix && col_ext < CNT_W'(MAX_COLS);
  assign re        = accept && is_matrix;

  // Matrix elements beyond the columns in use neither add nor finish a row.
  assign s1_ctl_next.valid = re && col_ext < eff_cols;
  assign s1_ctl_next.last  = col_ext == eff_cols - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl <= s1_ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    s1_value <= in_data.value;
  end

  mvm_vec_store #(
    .MAX_COLS (MAX_COLS),
    .ADDR_W   (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .re    (re),
    .addr  (ADDR_W'(in_data.col)),
    .wdata (in_data.value),
    .rdata (vec_rdata)
  );

  mvm_mac u_mac (
    .clk         (clk),
    .rst         (rst),
    .s1_ctl      (s1_ctl),
    .a           (s1_value),
    .b           (vec_rdata),
    .rows_in_use (rows_in_use),
    .res_valid   (res_valid),
    .res         (res),
    .pending     (pending)
  );

  mvm_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (fifo_count)
  );

  // Every row result in flight has a queue entry reserved for it.
  assign in_flight = TOT_W'(fifo_count) + TOT_W'(pending)
                   + TOT_W'(s1_ctl.valid && s1_ctl.last);
  assign in_stall  = in_flight >= TOT_W'(FIFO_DEPTH);

  `MVM_ASSERT(a_inflight_bound, clk, rst, in_flight <= TOT_W'(FIFO_DEPTH))
  `MVM_ASSERT(a_single_access, clk, rst, !(we && re))

endmodule
